// File: rtl/core/bptc_pkg.sv
`default_nettype none

package bptc_pkg;

    localparam int unsigned RAW_W   = 24;
    localparam int unsigned CAL_W   = 16;
    localparam int unsigned TEMP_W  = 19;
    localparam int unsigned PRES_W  = 32;
    localparam int unsigned WIDE_W  = 40;
    localparam int unsigned PROD_W  = 64;
    localparam int unsigned NSTG    = 8;

    localparam int unsigned S_DATA_W = 48;
    localparam int unsigned M_DATA_W = 56;

    localparam logic [2:0] CFG_SENS      = 3'd0;
    localparam logic [2:0] CFG_OFF       = 3'd1;
    localparam logic [2:0] CFG_TCS       = 3'd2;
    localparam logic [2:0] CFG_TCO       = 3'd3;
    localparam logic [2:0] CFG_TREF      = 3'd4;
    localparam logic [2:0] CFG_TEMPSENS  = 3'd5;
    localparam logic [2:0] CFG_SO_EN     = 3'd6;

    localparam logic signed [TEMP_W-1:0] TEMP_REF = 19'sd2000;
    localparam logic [16:0]              T_LOW    = 17'd3500;

endpackage

`default_nettype wire

// File: rtl/core/baro_pressure_temp_compensation_top.sv
// Barometric pressure and temperature compensation with second-order correction.
// Input stream s_axis: one word per sample pair, raw pressure and raw temperature
// conversion results. Output stream m_axis: compensated temperature in 0.01 degC
// and compensated pressure in 0.01 mbar (low 32 bits, two's complement).
// Calibration words and the second-order enable are written through the plain
// write port (i_cfg_wr_en, i_cfg_addr, i_cfg_wr_data); the user must write them
// only while no word is in flight, as the block itself does not enforce this.
// The path has eight register stages:
// offset magnitude, scaling products, first-order terms and squares,
// second-order terms, correction, split pressure products, product sum, and
// the final pressure shift into the output register.
// Throughput: one word per cycle while m_axis_tready lets the output move.
// Each stage has its own valid bit and loads when it is empty or the next stage
// moves, so bubbles close up and input is taken while a result waits.
// When m_axis_tready is low the output word holds; a word behind it stalls only
// once every stage ahead of it is full, and nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous) empties the pipeline, clears the calibration
// words to zero and sets the second-order enable.
`default_nettype none

module baro_pressure_temp_compensation_top
    import bptc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // raw_pressure [23:0], raw_temperature [47:24]
    input  wire logic [S_DATA_W-1:0]   s_axis_tdata,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // temperature_centi_deg [18:0], pressure_centi_mbar [50:19], zero [55:51]
    output logic [M_DATA_W-1:0]        m_axis_tdata,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [2:0]            i_cfg_addr,
    input  wire logic [CAL_W-1:0]      i_cfg_wr_data
);

    logic [CAL_W-1:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;
    logic             r_so_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1    <= '0;
            r_c2    <= '0;
            r_c3    <= '0;
            r_c4    <= '0;
            r_c5    <= '0;
            r_c6    <= '0;
            r_so_en <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_SENS:     r_c1    <= i_cfg_wr_data;
                CFG_OFF:      r_c2    <= i_cfg_wr_data;
                CFG_TCS:      r_c3    <= i_cfg_wr_data;
                CFG_TCO:      r_c4    <= i_cfg_wr_data;
                CFG_TREF:     r_c5    <= i_cfg_wr_data;
                CFG_TEMPSENS: r_c6    <= i_cfg_wr_data;
                CFG_SO_EN:    r_so_en <= i_cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // stage valids and load enables
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] w_en;

    always_comb begin
        w_en[NSTG-1] = !r_vld[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_axis_tready = w_en[0];
    assign m_axis_tvalid = r_vld[NSTG-1];

    // stage 1: temperature offset as magnitude and sign
    logic [RAW_W-1:0] w_d1, w_d2, w_tref;
    logic             n1_below;
    logic [RAW_W-1:0] n1_mag;
    logic [RAW_W-1:0] r1_d1, r1_mag;
    logic             r1_below;

    assign w_d1   = s_axis_tdata[RAW_W-1:0];
    assign w_d2   = s_axis_tdata[2*RAW_W-1:RAW_W];
    assign w_tref = {r_c5, 8'h00};

    always_comb begin
        n1_below = w_d2 < w_tref;
        n1_mag   = n1_below ? (w_tref - w_d2) : (w_d2 - w_tref);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_d1    <= w_d1;
            r1_mag   <= n1_mag;
            r1_below <= n1_below;
        end
    end

    // stage 2: scaling products
    logic [39:0] n2_pt, n2_po, n2_ps;
    logic [47:0] n2_pm;
    logic [16:0] r2_t_term, r2_t2;
    logic [32:0] r2_o_term;
    logic [31:0] r2_s_term;
    logic [RAW_W-1:0] r2_d1;
    logic        r2_below;

    always_comb begin
        n2_pt = r1_mag * r_c6;
        n2_po = r1_mag * r_c4;
        n2_ps = r1_mag * r_c3;
        n2_pm = r1_mag * r1_mag;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_t_term <= n2_pt[39:23];
            r2_o_term <= n2_po[39:7];
            r2_s_term <= n2_ps[39:8];
            r2_t2     <= n2_pm[47:31];
            r2_d1     <= r1_d1;
            r2_below  <= r1_below;
        end
    end

    // stage 3: first-order terms and squares
    logic signed [TEMP_W-1:0] n3_t_ext, n3_temp;
    logic signed [WIDE_W-1:0] n3_o_base, n3_o_t, n3_s_base, n3_s_t, n3_off, n3_sens;
    logic [16:0] n3_em;
    logic [33:0] n3_tsq, n3_q;
    logic signed [TEMP_W-1:0] r3_temp;
    logic signed [WIDE_W-1:0] r3_off, r3_sens;
    logic [33:0] r3_tsq, r3_q;
    logic        r3_so, r3_low;
    logic [16:0] r3_t2;
    logic [RAW_W-1:0] r3_d1;

    always_comb begin
        n3_t_ext  = signed'({2'b00, r2_t_term});
        n3_o_base = signed'({8'h00, r_c2, 16'h0000});
        n3_o_t    = signed'({7'h00, r2_o_term});
        n3_s_base = signed'({9'h000, r_c1, 15'h0000});
        n3_s_t    = signed'({8'h00, r2_s_term});
        n3_temp   = r2_below ? (TEMP_REF - n3_t_ext) : (TEMP_REF + n3_t_ext);
        n3_off    = r2_below ? (n3_o_base - n3_o_t) : (n3_o_base + n3_o_t);
        n3_sens   = r2_below ? (n3_s_base - n3_s_t) : (n3_s_base + n3_s_t);
        n3_em     = r2_t_term - T_LOW;
        n3_tsq    = r2_t_term * r2_t_term;
        n3_q      = n3_em * n3_em;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_temp <= n3_temp;
            r3_off  <= n3_off;
            r3_sens <= n3_sens;
            r3_tsq  <= n3_tsq;
            r3_q    <= n3_q;
            r3_so   <= r_so_en && r2_below && (r2_t_term != '0);
            r3_low  <= r2_t_term > T_LOW;
            r3_t2   <= r2_t2;
            r3_d1   <= r2_d1;
        end
    end

    // stage 4: second-order offset and sensitivity terms
    logic [36:0] n4_tsq5, n4_q7;
    logic [37:0] n4_q11;
    logic [35:0] n4_off2a;
    logic [37:0] n4_off2, n4_sens2;
    logic signed [TEMP_W-1:0] r4_temp;
    logic signed [WIDE_W-1:0] r4_off, r4_sens;
    logic [37:0] r4_off2, r4_sens2;
    logic        r4_so;
    logic [16:0] r4_t2;
    logic [RAW_W-1:0] r4_d1;

    always_comb begin
        n4_tsq5  = {3'b000, r3_tsq} + {1'b0, r3_tsq, 2'b00};
        n4_q7    = {r3_q, 3'b000} - {3'b000, r3_q};
        n4_q11   = {1'b0, r3_q, 3'b000} + {3'b000, r3_q, 1'b0} + {4'h0, r3_q};
        n4_off2a = n4_tsq5[36:1];
        n4_off2  = {2'b00, n4_off2a} + (r3_low ? {1'b0, n4_q7} : 38'd0);
        n4_sens2 = {3'b000, n4_off2a[35:1]} + (r3_low ? {1'b0, n4_q11[37:1]} : 38'd0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r4_temp  <= r3_temp;
            r4_off   <= r3_off;
            r4_sens  <= r3_sens;
            r4_off2  <= n4_off2;
            r4_sens2 <= n4_sens2;
            r4_so    <= r3_so;
            r4_t2    <= r3_t2;
            r4_d1    <= r3_d1;
        end
    end

    // stage 5: apply the correction
    logic signed [TEMP_W-1:0] r5_temp;
    logic signed [WIDE_W-1:0] r5_off, r5_sens;
    logic [RAW_W-1:0] r5_d1;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            if (r4_so) begin
                r5_temp <= r4_temp - signed'({2'b00, r4_t2});
                r5_off  <= r4_off - signed'({2'b00, r4_off2});
                r5_sens <= r4_sens - signed'({2'b00, r4_sens2});
            end else begin
                r5_temp <= r4_temp;
                r5_off  <= r4_off;
                r5_sens <= r4_sens;
            end
            r5_d1 <= r4_d1;
        end
    end

    // stage 6: pressure product in two halves
    logic [43:0]        n6_pl;
    logic signed [44:0] n6_ph;
    logic [43:0]        r6_pl;
    logic signed [44:0] r6_ph;
    logic signed [TEMP_W-1:0] r6_temp;
    logic signed [WIDE_W-1:0] r6_off;

    always_comb begin
        n6_pl = r5_sens[19:0] * r5_d1;
        n6_ph = $signed({1'b0, r5_d1}) * $signed(r5_sens[39:20]);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r6_pl   <= n6_pl;
            r6_ph   <= n6_ph;
            r6_temp <= r5_temp;
            r6_off  <= r5_off;
        end
    end

    // stage 7: sum the halves
    logic [PROD_W-1:0]        r7_prod;
    logic signed [TEMP_W-1:0] r7_temp;
    logic signed [WIDE_W-1:0] r7_off;

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r7_prod <= {r6_ph[43:0], 20'h00000} + {20'h00000, r6_pl};
            r7_temp <= r6_temp;
            r7_off  <= r6_off;
        end
    end

    // stage 8: subtract offset, scale, output register
    logic [PROD_W-1:0] n8_diff;
    logic [PRES_W-1:0] r8_pres;
    logic [TEMP_W-1:0] r8_temp;

    assign n8_diff = {{21{r7_prod[63]}}, r7_prod[63:21]} - {{24{r7_off[39]}}, r7_off};

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r8_pres <= n8_diff[46:15];
            r8_temp <= r7_temp;
        end
    end

    assign m_axis_tdata = {5'b00000, r8_pres, r8_temp};

endmodule

`default_nettype wire

// File: tb/baro_pressure_temp_compensation_top_tb.sv
module baro_pressure_temp_compensation_top_tb;
    import bptc_pkg::*;

    localparam logic [2:0]       CFG_UNUSED  = 3'd7;
    localparam int               CYCLE_LIMIT = 400000;
    localparam int               RANDOM_PHASES = 8;
    localparam int               PHASE_WORDS = 212;
    localparam logic [RAW_W-1:0] RAW_MAX = '1;
    localparam logic [CAL_W-1:0] CAL_MAX = '1;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic [PRES_W-1:0] pres;
    } t_reading;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                i_cfg_wr_en = 1'b0;
    logic [2:0]          i_cfg_addr = '0;
    logic [CAL_W-1:0]    i_cfg_wr_data = '0;

    longint   cal_sens = 0;
    longint   cal_off = 0;
    longint   cal_tcs = 0;
    longint   cal_tco = 0;
    longint   cal_tref = 0;
    longint   cal_tempsens = 0;
    bit       so_enable = 1'b1;
    t_reading pending_readings[$];
    int       mismatch_count = 0;
    int       cycle_count = 0;
    int       rx_hold = 0;
    bit       idle_on = 1'b1;

    baro_pressure_temp_compensation_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_reading compensate(input logic [RAW_W-1:0] d1,
                                            input logic [RAW_W-1:0] d2);
        longint   centre, raw_t, mag, temp_c, off, sens, t2, diff, off2, sens2, q, p;
        bit       below;
        t_reading r;
        centre = cal_tref << 8;
        raw_t  = longint'(d2);
        below  = raw_t < centre;
        mag    = below ? centre - raw_t : raw_t - centre;
        if (below) begin
            temp_c = 2000 - ((mag * cal_tempsens) >> 23);
            off    = (cal_off << 16) - ((mag * cal_tco) >> 7);
            sens   = (cal_sens << 15) - ((mag * cal_tcs) >> 8);
        end else begin
            temp_c = 2000 + ((mag * cal_tempsens) >> 23);
            off    = (cal_off << 16) + ((mag * cal_tco) >> 7);
            sens   = (cal_sens << 15) + ((mag * cal_tcs) >> 8);
        end
        if (so_enable && temp_c < 2000) begin
            t2    = (mag * mag) >> 31;
            diff  = temp_c - 2000;
            off2  = (5 * diff * diff) / 2;
            sens2 = off2 / 2;
            if (temp_c < -1500) begin
                q     = (temp_c + 1500) * (temp_c + 1500);
                off2  = off2 + 7 * q;
                sens2 = sens2 + (11 * q) / 2;
            end
            temp_c = temp_c - t2;
            off    = off - off2;
            sens   = sens - sens2;
        end
        p = (longint'(d1) * sens) >>> 21;
        p = (p - off) >>> 15;
        r.temp = temp_c[TEMP_W-1:0];
        r.pres = p[PRES_W-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatch_count++;
        $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want, cycle_count);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [CAL_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_addr    <= idx;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
        case (idx)
            CFG_SENS:     cal_sens = longint'(value);
            CFG_OFF:      cal_off = longint'(value);
            CFG_TCS:      cal_tcs = longint'(value);
            CFG_TCO:      cal_tco = longint'(value);
            CFG_TREF:     cal_tref = longint'(value);
            CFG_TEMPSENS: cal_tempsens = longint'(value);
            CFG_SO_EN:    so_enable = value[0];
            default:      ;
        endcase
    endtask

    task automatic set_calibration(input logic [CAL_W-1:0] c1, input logic [CAL_W-1:0] c2,
                                   input logic [CAL_W-1:0] c3, input logic [CAL_W-1:0] c4,
                                   input logic [CAL_W-1:0] c5, input logic [CAL_W-1:0] c6,
                                   input logic [CAL_W-1:0] so);
        write_reg(CFG_SENS, c1);
        write_reg(CFG_OFF, c2);
        write_reg(CFG_TCS, c3);
        write_reg(CFG_TCO, c4);
        write_reg(CFG_TREF, c5);
        write_reg(CFG_TEMPSENS, c6);
        write_reg(CFG_SO_EN, so);
    endtask

    task automatic send_sample(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        repeat (gap) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {d2, d1};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_readings.push_back(compensate(d1, d2));
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(negedge i_clk);
        repeat (NSTG) @(negedge i_clk);
    endtask

    function automatic logic [CAL_W-1:0] pick_cal();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CAL_MAX;
            default: return CAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] pick_pressure_raw();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return RAW_MAX;
            default: return RAW_W'($urandom);
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] pick_temperature_raw();
        longint centre, v;
        centre = cal_tref << 8;
        case ($urandom_range(0, 3))
            0:       v = centre + longint'($urandom_range(0, 8192)) - 4096;
            1:       v = longint'($urandom_range(0, int'(centre)));
            default: v = longint'($urandom_range(0, RAW_MAX));
        endcase
        if (v < 0)
            v = 0;
        if (v > longint'(RAW_MAX))
            v = longint'(RAW_MAX);
        return v[RAW_W-1:0];
    endfunction

    task automatic test_reset_values();
        send_sample('0, '0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample(24'h123456, 24'h654321);
        wait_idle();
    endtask

    task automatic test_typical_calibration();
        set_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312,
                        16'd1);
        send_sample(24'd9085466, 24'd8569150);
        send_sample(24'd9085466, 24'd8566784);
        send_sample(24'd9085466, 24'd8566484);
        send_sample(24'd9085466, 24'd7866784);
        send_sample(24'd9085466, '0);
        send_sample(24'd9085466, RAW_MAX);
        send_sample('0, 24'd1000000);
        send_sample(RAW_MAX, '0);
        send_sample(RAW_MAX, RAW_MAX);
        wait_idle();
    endtask

    task automatic test_first_order_only();
        write_reg(CFG_SO_EN, '0);
        send_sample(24'd9085466, 24'd8566484);
        send_sample(24'd9085466, 24'd7866784);
        send_sample(24'd9085466, '0);
        send_sample(RAW_MAX, '0);
        send_sample('0, RAW_MAX);
        wait_idle();
    endtask

    task automatic test_unknown_index();
        write_reg(CFG_UNUSED, CAL_MAX);
        send_sample(24'd9085466, 24'd8569150);
        send_sample(RAW_MAX, 24'd2000000);
        wait_idle();
    endtask

    task automatic test_calibration_extremes();
        set_calibration(CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, 16'd1);
        send_sample(RAW_MAX, '0);
        send_sample('0, '0);
        send_sample(RAW_MAX, RAW_MAX);
        wait_idle();
        set_calibration('0, '0, '0, '0, CAL_MAX, CAL_MAX, 16'd1);
        send_sample(RAW_MAX, '0);
        send_sample(24'd1, 24'd12345);
        wait_idle();
        set_calibration(CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, '0, CAL_MAX, 16'd0);
        send_sample(RAW_MAX, RAW_MAX);
        wait_idle();
    endtask

    task automatic test_random_stream(input int words);
        set_calibration(pick_cal(), pick_cal(), pick_cal(), pick_cal(), pick_cal(),
                        pick_cal(), CAL_W'($urandom_range(0, 1)));
        for (int n = 0; n < words; n++) begin
            send_sample(pick_pressure_raw(), pick_temperature_raw());
            if (n == words / 2)
                wait_idle();
        end
        wait_idle();
    endtask

    task automatic test_back_to_back(input int words);
        idle_on = 1'b0;
        test_random_stream(words);
        idle_on = 1'b1;
    endtask

    always @(negedge i_clk) begin
        if (rx_hold != 0) begin
            m_axis_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            rx_hold = idle_on ? $urandom_range(0, 4) : 0;
            if (pending_readings.size() == 0) begin
                flag_mismatch("unexpected word", 64'(m_axis_tdata), '0);
            end else begin
                want = pending_readings.pop_front();
                if (m_axis_tdata[TEMP_W-1:0] !== want.temp)
                    flag_mismatch("temperature", 64'(m_axis_tdata[TEMP_W-1:0]),
                                  64'(want.temp));
                if (m_axis_tdata[TEMP_W+PRES_W-1:TEMP_W] !== want.pres)
                    flag_mismatch("pressure", 64'(m_axis_tdata[TEMP_W+PRES_W-1:TEMP_W]),
                                  64'(want.pres));
                if (m_axis_tdata[M_DATA_W-1:TEMP_W+PRES_W] !== '0)
                    flag_mismatch("pad bits", 64'(m_axis_tdata[M_DATA_W-1:TEMP_W+PRES_W]),
                                  '0);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_reset_values();
        test_typical_calibration();
        test_first_order_only();
        test_unknown_index();
        test_calibration_extremes();
        for (int k = 0; k < RANDOM_PHASES; k++)
            test_random_stream(PHASE_WORDS);
        test_back_to_back(PHASE_WORDS);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: baro_pressure_temp_compensation_top.f
rtl/core/bptc_pkg.sv
rtl/core/baro_pressure_temp_compensation_top.sv
tb/baro_pressure_temp_compensation_top_tb.sv
